// File: rtl/gsra_pkg.sv
`default_nettype none
package gsra_pkg;

  // field widths
  localparam int unsigned PosW     = 34;
  localparam int unsigned OutPosW  = 35;
  localparam int unsigned HdgW     = 16;
  localparam int unsigned QualW    = 4;
  localparam int unsigned StatW    = 2;
  localparam int unsigned AccPosW  = 42;
  localparam int unsigned AccHdgW  = 24;
  localparam int unsigned CntW     = 9;
  localparam int unsigned SampW    = 8;
  localparam int unsigned TolW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned UnitW    = 43;
  localparam int unsigned DivCntW  = 6;

  // result status codes
  localparam logic [StatW-1:0] STATUS_NO_RTK   = 2'd0;
  localparam logic [StatW-1:0] STATUS_COLLECT  = 2'd1;
  localparam logic [StatW-1:0] STATUS_REF_SET  = 2'd2;
  localparam logic [StatW-1:0] STATUS_RELATIVE = 2'd3;

  // quality codes
  localparam logic [QualW-1:0] POS_Q_RTK_FIXED = 4'd3;
  localparam logic [QualW-1:0] HDG_Q_FLOAT     = 4'd2;
  localparam logic [QualW-1:0] HDG_Q_FIXED     = 4'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POS_TOL      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HDG_TOL      = 2'd2;

  // register reset values
  localparam logic [SampW-1:0] SAMPLE_COUNT_RST = 8'd40;
  localparam logic [TolW-1:0]  POS_TOL_RST      = 16'd30;
  localparam logic [TolW-1:0]  HDG_TOL_RST      = 16'd30;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIFF_E,
    ST_TEST_E,
    ST_DIFF_N,
    ST_TEST_N,
    ST_DIFF_H,
    ST_TEST_H,
    ST_ACC_E,
    ST_ACC_N,
    ST_ACC_H,
    ST_REL_E,
    ST_REL_N,
    ST_DIV_E,
    ST_DIV_N,
    ST_DIV_H,
    ST_DONE
  } gsra_state_e;

endpackage
`default_nettype wire

// File: rtl/gsra_in_if.sv
`default_nettype none
interface gsra_in_if import gsra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PosW-1:0]   east_mm;
  logic [PosW-1:0]   north_mm;
  logic [HdgW-1:0]   heading_cdeg;
  logic [QualW-1:0]  position_quality;
  logic [QualW-1:0]  heading_quality;

  modport source (output valid, east_mm, north_mm, heading_cdeg, position_quality,
                  heading_quality, input ready);
  modport sink   (input valid, east_mm, north_mm, heading_cdeg, position_quality,
                  heading_quality, output ready);
endinterface
`default_nettype wire

// File: rtl/gsra_out_if.sv
`default_nettype none
interface gsra_out_if import gsra_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [StatW-1:0]          status;
  logic signed [OutPosW-1:0] pos_east;
  logic signed [OutPosW-1:0] pos_north;
  logic [HdgW-1:0]           heading_out;
  logic [HdgW-1:0]           avg_heading;

  modport source (output valid, status, pos_east, pos_north, heading_out, avg_heading,
                  input ready);
  modport sink   (input valid, status, pos_east, pos_north, heading_out, avg_heading,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/gsra_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, MSB first.
module gsra_div import gsra_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [AccPosW-1:0] dividend_i,
  input  wire logic [SampW-1:0]   divisor_i,
  output logic                    done_o,
  output logic [AccPosW-1:0]      quot_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [AccPosW-1:0] dq_q;   // dividend shifts out at the top, quotient in at the bottom
  logic [SampW-1:0]   rem_q, rem_d;
  logic [SampW-1:0]   dvs_q;
  logic [SampW:0]     trial;
  logic [SampW:0]     trial_sub;
  logic               ge;

  always_comb begin
    trial     = {rem_q, dq_q[AccPosW-1]};
    trial_sub = trial - {1'b0, dvs_q};
    ge        = (trial >= {1'b0, dvs_q});
    rem_d     = ge ? trial_sub[SampW-1:0] : trial[SampW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(AccPosW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[AccPosW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
`default_nettype wire

// File: rtl/gnss_stable_reference_averager_core.sv
`default_nettype none
// An unqualified or seeding fix goes straight to done, a relative fix subtracts the reference,
//   a collecting fix tests the axes and on a pass sums them; the reference fix runs three divides.
// Throughput: one request at a time; the next is taken once the result sits in the output register.
// The shared adder/subtractor and the single radix-2 divider do this work.
// Reset (rst_ni, async, active low): registers back to 40 / 30 / 30, sums, count, last fix and
//   reference cleared, block collecting, output empty.
module gnss_stable_reference_averager_core import gsra_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  gsra_in_if.sink                  in_ch,
  gsra_out_if.source               out_ch,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  gsra_state_e state_q, state_d;

  // configuration
  logic [SampW-1:0] sample_count_q;
  logic [TolW-1:0]  pos_tol_q, hdg_tol_q;

  // averaging state
  logic [CntW-1:0]    stable_count_q;
  logic [PosW-1:0]    prev_east_q, prev_north_q;
  logic [HdgW-1:0]    prev_heading_q;
  logic [AccPosW-1:0] acc_east_q, acc_north_q;
  logic [AccHdgW-1:0] acc_heading_q;
  logic [PosW-1:0]    ref_east_q, ref_north_q;
  logic [HdgW-1:0]    ref_heading_q;
  logic               ref_valid_q;

  // captured request
  logic [PosW-1:0]  in_east_q, in_north_q;
  logic [HdgW-1:0]  in_heading_q;
  logic [QualW-1:0] in_pq_q, in_hq_q;

  // working result
  logic [StatW-1:0]   res_status_q;
  logic [OutPosW-1:0] res_pe_q, res_pn_q;
  logic [UnitW-1:0]   diff_q;

  // output register
  logic               out_valid_q;
  logic [StatW-1:0]   out_status_q;
  logic [OutPosW-1:0] out_pe_q, out_pn_q;
  logic [HdgW-1:0]    out_hdg_q, out_avg_q;

  // shared adder/subtractor
  logic [UnitW-1:0] ua, ub, ures;
  logic             usub;

  // divider
  logic               div_start, div_done;
  logic [AccPosW-1:0] div_dividend, div_quot;
  logic [SampW-1:0]   divisor;

  // decode
  logic qualified, trigger, test_pass, out_free;
  logic [TolW-1:0] tol_sel;

  assign divisor   = (sample_count_q == '0) ? SampW'(1) : sample_count_q;
  assign qualified = (in_pq_q == POS_Q_RTK_FIXED) &&
                     ((in_hq_q == HDG_Q_FLOAT) || (in_hq_q == HDG_Q_FIXED));
  // enough stable fixes gathered: average on this one
  assign trigger   = (stable_count_q >= ({1'b0, divisor} + CntW'(1)));
  assign out_free  = !out_valid_q || out_ch.ready;

  assign ures = ua + (usub ? ~ub : ub) + UnitW'(usub);

  // |a-b| < tol: for a non-negative difference test diff-tol < 0,
  // for a negative one test diff+tol > 0
  assign test_pass = diff_q[UnitW-1] ? (!ures[UnitW-1] && (ures != '0)) : ures[UnitW-1];

  gsra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_ch.valid) state_d = ST_DECIDE;
      ST_DECIDE: begin
        priority if (!qualified)             state_d = ST_DONE;
        else if (ref_valid_q)                state_d = ST_REL_E;
        else if (stable_count_q == '0)       state_d = ST_DONE;
        else if (!trigger)                   state_d = ST_DIFF_E;
        else                                 state_d = ST_DIV_E;
      end
      ST_DIFF_E: state_d = ST_TEST_E;
      ST_TEST_E: state_d = test_pass ? ST_DIFF_N : ST_DONE;
      ST_DIFF_N: state_d = ST_TEST_N;
      ST_TEST_N: state_d = test_pass ? ST_DIFF_H : ST_DONE;
      ST_DIFF_H: state_d = ST_TEST_H;
      ST_TEST_H: state_d = test_pass ? ST_ACC_E : ST_DONE;
      ST_ACC_E:  state_d = ST_ACC_N;
      ST_ACC_N:  state_d = ST_ACC_H;
      ST_ACC_H:  state_d = ST_DONE;
      ST_REL_E:  state_d = ST_REL_N;
      ST_REL_N:  state_d = ST_DONE;
      ST_DIV_E:  if (div_done) state_d = ST_DIV_N;
      ST_DIV_N:  if (div_done) state_d = ST_DIV_H;
      ST_DIV_H:  if (div_done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath steering
  always_comb begin
    ua           = '0;
    ub           = '0;
    usub         = 1'b0;
    tol_sel      = pos_tol_q;
    div_start    = 1'b0;
    div_dividend = acc_east_q;
    unique case (state_q)
      ST_DIFF_E: begin
        ua = UnitW'(in_east_q);  ub = UnitW'(prev_east_q);  usub = 1'b1;
      end
      ST_DIFF_N: begin
        ua = UnitW'(in_north_q); ub = UnitW'(prev_north_q); usub = 1'b1;
      end
      ST_DIFF_H: begin
        ua = UnitW'(in_heading_q); ub = UnitW'(prev_heading_q); usub = 1'b1;
      end
      ST_TEST_E, ST_TEST_N, ST_TEST_H: begin
        tol_sel = (state_q == ST_TEST_H) ? hdg_tol_q : pos_tol_q;
        ua      = diff_q;
        ub      = UnitW'(tol_sel);
        usub    = !diff_q[UnitW-1];
      end
      ST_ACC_E: begin ua = UnitW'(acc_east_q);    ub = UnitW'(in_east_q);    end
      ST_ACC_N: begin ua = UnitW'(acc_north_q);   ub = UnitW'(in_north_q);   end
      ST_ACC_H: begin ua = UnitW'(acc_heading_q); ub = UnitW'(in_heading_q); end
      ST_REL_E: begin
        ua = UnitW'(in_east_q);  ub = UnitW'(ref_east_q);  usub = 1'b1;
      end
      ST_REL_N: begin
        ua = UnitW'(in_north_q); ub = UnitW'(ref_north_q); usub = 1'b1;
      end
      ST_DECIDE: begin
        div_start    = qualified && !ref_valid_q && (stable_count_q != '0) && trigger;
        div_dividend = acc_east_q;
      end
      ST_DIV_E: begin
        div_start    = div_done;
        div_dividend = acc_north_q;
      end
      ST_DIV_N: begin
        div_start    = div_done;
        div_dividend = AccPosW'(acc_heading_q);
      end
      default: ;
    endcase
  end

  // control and averaging state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      sample_count_q <= SAMPLE_COUNT_RST;
      pos_tol_q      <= POS_TOL_RST;
      hdg_tol_q      <= HDG_TOL_RST;
      stable_count_q <= '0;
      prev_east_q    <= '0;
      prev_north_q   <= '0;
      prev_heading_q <= '0;
      acc_east_q     <= '0;
      acc_north_q    <= '0;
      acc_heading_q  <= '0;
      ref_east_q     <= '0;
      ref_north_q    <= '0;
      ref_heading_q  <= '0;
      ref_valid_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SAMPLE_COUNT: sample_count_q <= cfg_wdata_i[SampW-1:0];
          CFG_POS_TOL:      pos_tol_q      <= cfg_wdata_i[TolW-1:0];
          CFG_HDG_TOL:      hdg_tol_q      <= cfg_wdata_i[TolW-1:0];
          default: ;  // no register here
        endcase
      end

      if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
      else if (out_ch.ready)                out_valid_q <= 1'b0;

      unique case (state_q)
        ST_DECIDE: begin
          // first qualified fix only seeds
          if (qualified && !ref_valid_q && (stable_count_q == '0)) begin
            stable_count_q <= CntW'(1);
            prev_east_q    <= in_east_q;
            prev_north_q   <= in_north_q;
            prev_heading_q <= in_heading_q;
          end
        end
        ST_TEST_E, ST_TEST_N, ST_TEST_H: begin
          // jump: drop the run, next fix seeds again
          if (!test_pass) begin
            stable_count_q <= '0;
            acc_east_q     <= '0;
            acc_north_q    <= '0;
            acc_heading_q  <= '0;
          end
        end
        ST_ACC_E: acc_east_q  <= ures[AccPosW-1:0];
        ST_ACC_N: acc_north_q <= ures[AccPosW-1:0];
        ST_ACC_H: begin
          acc_heading_q  <= ures[AccHdgW-1:0];
          stable_count_q <= stable_count_q + CntW'(1);
          prev_east_q    <= in_east_q;
          prev_north_q   <= in_north_q;
          prev_heading_q <= in_heading_q;
        end
        ST_DIV_E: if (div_done) ref_east_q  <= div_quot[PosW-1:0];
        ST_DIV_N: if (div_done) ref_north_q <= div_quot[PosW-1:0];
        ST_DIV_H: begin
          if (div_done) begin
            ref_heading_q <= div_quot[HdgW-1:0];
            ref_valid_q   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // request capture, working result and output payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_ch.valid) begin
      in_east_q    <= in_ch.east_mm;
      in_north_q   <= in_ch.north_mm;
      in_heading_q <= in_ch.heading_cdeg;
      in_pq_q      <= in_ch.position_quality;
      in_hq_q      <= in_ch.heading_quality;
    end

    if ((state_q == ST_DIFF_E) || (state_q == ST_DIFF_N) || (state_q == ST_DIFF_H)) begin
      diff_q <= ures;
    end

    unique case (state_q)
      ST_DECIDE: begin
        res_pe_q     <= '0;
        res_pn_q     <= '0;
        res_status_q <= qualified ? STATUS_COLLECT : STATUS_NO_RTK;
      end
      ST_REL_E: begin
        res_status_q <= STATUS_RELATIVE;
        res_pe_q     <= ures[OutPosW-1:0];
      end
      ST_REL_N: res_pn_q <= ures[OutPosW-1:0];
      ST_DIV_H: begin
        if (div_done) begin
          res_status_q <= STATUS_REF_SET;
          res_pe_q     <= OutPosW'(in_east_q);
          res_pn_q     <= OutPosW'(in_north_q);
        end
      end
      default: ;
    endcase

    if ((state_q == ST_DONE) && out_free) begin
      out_status_q <= res_status_q;
      out_pe_q     <= res_pe_q;
      out_pn_q     <= res_pn_q;
      out_hdg_q    <= in_heading_q;
      out_avg_q    <= ref_valid_q ? ref_heading_q : '0;
    end
  end

  assign in_ch.ready        = (state_q == ST_IDLE);
  assign out_ch.valid       = out_valid_q;
  assign out_ch.status      = out_status_q;
  assign out_ch.pos_east    = out_pe_q;
  assign out_ch.pos_north   = out_pn_q;
  assign out_ch.heading_out = out_hdg_q;
  assign out_ch.avg_heading = out_avg_q;

endmodule
`default_nettype wire

// File: tb/sv/gnss_stable_reference_averager_core_tb.sv
`timescale 1ns / 1ps

import gsra_pkg::*;

typedef struct packed {
  logic [PosW-1:0]  east;
  logic [PosW-1:0]  north;
  logic [HdgW-1:0]  heading;
  logic [QualW-1:0] pos_q;
  logic [QualW-1:0] hdg_q;
} fix_t;

typedef struct packed {
  logic [StatW-1:0]          status;
  logic signed [OutPosW-1:0] east;
  logic signed [OutPosW-1:0] north;
  logic [HdgW-1:0]           heading;
  logic [HdgW-1:0]           avg_heading;
} report_t;

// Tracks the averaging state and holds the reports still owed by the block.
class fix_tracker;
  logic [SampW-1:0]   samples;
  logic [TolW-1:0]    pos_tol;
  logic [TolW-1:0]    hdg_tol;
  logic [CntW-1:0]    stable_cnt;
  logic [PosW-1:0]    last_e, last_n;
  logic [HdgW-1:0]    last_h;
  logic [AccPosW-1:0] sum_e, sum_n;
  logic [AccHdgW-1:0] sum_h;
  logic [PosW-1:0]    ref_e, ref_n;
  logic [HdgW-1:0]    ref_h;
  bit                 referenced;
  report_t            expected_reports[$];
  int unsigned        errors;

  function new();
    samples    = SAMPLE_COUNT_RST;
    pos_tol    = POS_TOL_RST;
    hdg_tol    = HDG_TOL_RST;
    stable_cnt = '0;
    last_e     = '0;
    last_n     = '0;
    last_h     = '0;
    sum_e      = '0;
    sum_n      = '0;
    sum_h      = '0;
    ref_e      = '0;
    ref_n      = '0;
    ref_h      = '0;
    referenced = 1'b0;
    errors     = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_SAMPLE_COUNT: samples = data[SampW-1:0];
      CFG_POS_TOL:      pos_tol = data;
      CFG_HDG_TOL:      hdg_tol = data;
      default: ;
    endcase
  endfunction

  function logic [PosW-1:0] distance(logic [PosW-1:0] a, logic [PosW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function void take_fix(fix_t f);
    report_t      r;
    logic [SampW:0] divisor;
    bit           steady;
    r = '0;
    r.heading = f.heading;
    // zero samples behaves as one
    divisor = (samples == '0) ? (SampW+1)'(1) : {1'b0, samples};
    if (f.pos_q == POS_Q_RTK_FIXED && (f.hdg_q == HDG_Q_FLOAT || f.hdg_q == HDG_Q_FIXED)) begin
      if (referenced) begin
        r.status = STATUS_RELATIVE;
        r.east   = {1'b0, f.east} - {1'b0, ref_e};
        r.north  = {1'b0, f.north} - {1'b0, ref_n};
      end else if (stable_cnt == 0) begin
        r.status   = STATUS_COLLECT;
        stable_cnt = CntW'(1);
        last_e     = f.east;
        last_n     = f.north;
        last_h     = f.heading;
      end else if (stable_cnt < divisor + 1) begin
        r.status = STATUS_COLLECT;
        steady = distance(f.east, last_e) < pos_tol && distance(f.north, last_n) < pos_tol &&
                 distance(f.heading, last_h) < hdg_tol;
        if (steady) begin
          sum_e      = sum_e + f.east;
          sum_n      = sum_n + f.north;
          sum_h      = sum_h + f.heading;
          stable_cnt = stable_cnt + CntW'(1);
          last_e     = f.east;
          last_n     = f.north;
          last_h     = f.heading;
        end else begin
          // a jump drops the run; the last fix stays, so the next one seeds
          stable_cnt = '0;
          sum_e      = '0;
          sum_n      = '0;
          sum_h      = '0;
        end
      end else begin
        ref_e      = PosW'(sum_e / divisor);
        ref_n      = PosW'(sum_n / divisor);
        ref_h      = HdgW'(sum_h / divisor);
        referenced = 1'b1;
        r.status   = STATUS_REF_SET;
        r.east     = {1'b0, f.east};
        r.north    = {1'b0, f.north};
      end
    end
    r.avg_heading = referenced ? ref_h : '0;
    expected_reports.push_back(r);
  endfunction

  function void match_report(report_t got);
    report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t ns: unexpected report: status %0d east %0d north %0d heading %0d avg %0d",
               $time, got.status, got.east, got.north, got.heading, got.avg_heading);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    if (got !== want) begin
      $display("%0t ns: expected status %0d east %0d north %0d heading %0d avg %0d", $time,
               want.status, want.east, want.north, want.heading, want.avg_heading);
      $display("%0t ns: actual   status %0d east %0d north %0d heading %0d avg %0d", $time,
               got.status, got.east, got.north, got.heading, got.avg_heading);
      errors++;
    end
  endfunction
endclass

module gnss_stable_reference_averager_core_tb;

  // Generous: over 1100 requests, one reference divide.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleTicks = 4;
  localparam int unsigned DrainTicks  = 150;
  localparam int unsigned HeadingFull = 36000;

  localparam logic [PosW-1:0] PosTop = '1;

  // quality codes the block must reject
  localparam logic [QualW-1:0] Q_NONE      = 4'd0;
  localparam logic [QualW-1:0] Q_SINGLE    = 4'd1;
  localparam logic [QualW-1:0] POS_Q_FLOAT = 4'd2;
  localparam logic [QualW-1:0] Q_ABOVE     = 4'd4;
  localparam logic [QualW-1:0] Q_MAX       = 4'hF;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  gsra_in_if  fix_ch ();
  gsra_out_if report_ch ();

  gnss_stable_reference_averager_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (fix_ch),
    .out_ch      (report_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  fix_tracker     tracker;
  int unsigned    gap_pct = 12;   // idle share on both sides, per cent
  int unsigned    cycles  = 0;
  logic [PosW-1:0] anchor_e, anchor_n;
  logic [HdgW-1:0] anchor_h;

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost report ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("gnss_stable_reference_averager_core_tb failed");
      $finish;
    end
  end

  // Monitor and report sink. Reports are matched before the new request is noted, so a
  // request taken at the same edge always queues behind the one being answered.
  always @(posedge clk_i) begin
    report_t seen;
    fix_t    taken;
    if (rst_ni && report_ch.valid && report_ch.ready) begin
      seen.status      = report_ch.status;
      seen.east        = report_ch.pos_east;
      seen.north       = report_ch.pos_north;
      seen.heading     = report_ch.heading_out;
      seen.avg_heading = report_ch.avg_heading;
      tracker.match_report(seen);
    end
    if (rst_ni && fix_ch.valid && fix_ch.ready) begin
      taken.east    = fix_ch.east_mm;
      taken.north   = fix_ch.north_mm;
      taken.heading = fix_ch.heading_cdeg;
      taken.pos_q   = fix_ch.position_quality;
      taken.hdg_q   = fix_ch.heading_quality;
      tracker.take_fix(taken);
    end
    report_ch.ready <= ($urandom_range(0, 99) >= gap_pct);
  end

  // One fix request; returns at the edge where it was taken, valid still high so that the
  // next request can follow back to back.
  task automatic send_fix(input fix_t f);
    while ($urandom_range(0, 99) < gap_pct) begin
      fix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    fix_ch.valid            <= 1'b1;
    fix_ch.east_mm          <= f.east;
    fix_ch.north_mm         <= f.north;
    fix_ch.heading_cdeg     <= f.heading;
    fix_ch.position_quality <= f.pos_q;
    fix_ch.heading_quality  <= f.hdg_q;
    @(posedge clk_i);
    while (!fix_ch.ready) @(posedge clk_i);
  endtask

  // Register write, only once every report owed has come back.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    fix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  function automatic fix_t fix_of(input logic [PosW-1:0] e, input logic [PosW-1:0] n,
                                  input logic [HdgW-1:0] h, input logic [QualW-1:0] pq,
                                  input logic [QualW-1:0] hq);
    fix_t f;
    f.east    = e;
    f.north   = n;
    f.heading = h;
    f.pos_q   = pq;
    f.hdg_q   = hq;
    return f;
  endfunction

  // Anything at all, but never passing the RTK check.
  function automatic fix_t noise_fix();
    fix_t f;
    f.east    = PosW'({$urandom(), $urandom()});
    f.north   = PosW'({$urandom(), $urandom()});
    f.heading = HdgW'($urandom_range(0, 65535));
    f.pos_q   = QualW'($urandom_range(0, 15));
    f.hdg_q   = QualW'($urandom_range(0, 15));
    if (f.pos_q == POS_Q_RTK_FIXED && (f.hdg_q == HDG_Q_FLOAT || f.hdg_q == HDG_Q_FIXED))
      f.pos_q = f.pos_q ^ 4'($urandom_range(1, 15));
    return f;
  endfunction

  // Step below tolerance, now and then right at the edge (tol-1).
  function automatic longint unsigned step_size(input int unsigned tol);
    if (tol == 0) return 0;
    if ($urandom_range(0, 99) < 15) return 64'(tol - 1);
    return 64'($urandom_range(0, tol - 1));
  endfunction

  // Move a value by d either way, staying inside [0, top].
  function automatic longint unsigned nudge(input longint unsigned base, input longint unsigned d,
                                            input longint unsigned top);
    if (base >= d && (base + d > top || $urandom_range(0, 1) == 0)) return base - d;
    if (base + d <= top) return base + d;
    return base;
  endfunction

  // Collecting traffic: mostly steady runs around the anchor, some jumps, some noise.
  function automatic fix_t collect_fix(input int unsigned ptol, input int unsigned htol);
    int unsigned      roll;
    longint unsigned  de, dn, dh;
    roll = $urandom_range(0, 99);
    if (roll < 8) return noise_fix();
    de = step_size(ptol);
    dn = step_size(ptol);
    dh = step_size(htol);
    if (roll < 13) begin
      // one axis jumps by at least the tolerance
      case ($urandom_range(0, 2))
        0:       de = 64'(ptol + $urandom_range(0, 500));
        1:       dn = 64'(ptol + $urandom_range(0, 500));
        default: dh = 64'(htol + $urandom_range(0, 500));
      endcase
    end
    anchor_e = PosW'(nudge(64'(anchor_e), de, 64'(PosTop)));
    anchor_n = PosW'(nudge(64'(anchor_n), dn, 64'(PosTop)));
    anchor_h = HdgW'(nudge(64'(anchor_h), dh, 64'(HeadingFull)));
    return fix_of(anchor_e, anchor_n, anchor_h, POS_Q_RTK_FIXED,
                  $urandom_range(0, 1) ? HDG_Q_FIXED : HDG_Q_FLOAT);
  endfunction

  // Relative traffic: any position, extremes now and then, so offsets go negative and wrap.
  function automatic fix_t relative_fix();
    fix_t f;
    if ($urandom_range(0, 99) < 12) return noise_fix();
    f = noise_fix();
    case ($urandom_range(0, 9))
      0:       f.east = '0;
      1:       f.east = PosTop;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       f.north = '0;
      1:       f.north = PosTop;
      default: ;
    endcase
    f.heading = HdgW'($urandom_range(0, HeadingFull));
    f.pos_q   = POS_Q_RTK_FIXED;
    f.hdg_q   = $urandom_range(0, 1) ? HDG_Q_FIXED : HDG_Q_FLOAT;
    return f;
  endfunction

  initial begin
    int unsigned ptol, htol, runs;
    tracker                 = new();
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CFG_SAMPLE_COUNT;
    cfg_wdata_i             = '0;
    fix_ch.valid            = 1'b0;
    fix_ch.east_mm          = '0;
    fix_ch.north_mm         = '0;
    fix_ch.heading_cdeg     = '0;
    fix_ch.position_quality = '0;
    fix_ch.heading_quality  = '0;
    report_ch.ready         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- Directed, reset registers (40 / 30 / 30) ---
    // quality gate: each failing combination here leaves the state alone
    send_fix(fix_of('0, '0, '0, Q_NONE, Q_NONE));
    send_fix(fix_of(PosTop, PosTop, 16'hFFFF, Q_MAX, Q_MAX));
    send_fix(fix_of(1000000, 2000000, 100, POS_Q_RTK_FIXED, Q_SINGLE));
    send_fix(fix_of(1000000, 2000000, 100, POS_Q_RTK_FIXED, Q_ABOVE));
    send_fix(fix_of(1000000, 2000000, 100, POS_Q_FLOAT, HDG_Q_FIXED));
    // seed, then a step just under tolerance on every axis
    send_fix(fix_of(1000000, 2000000, 35990, POS_Q_RTK_FIXED, HDG_Q_FLOAT));
    send_fix(fix_of(1000029, 1999971, 35961, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    // easting step equal to tolerance is a jump; the fix after it seeds afresh
    send_fix(fix_of(1000059, 1999971, 35961, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    send_fix(fix_of(1000059, 1999971, 35961, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    send_fix(fix_of(1000059, 1999971, 35990, POS_Q_RTK_FIXED, HDG_Q_FLOAT));
    // heading across north does not wrap: 35990 -> 5 is a jump
    send_fix(fix_of(1000059, 1999971, 5, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    // top of the easting range, then a northing step equal to tolerance
    send_fix(fix_of(PosTop - 10, 10, 35995, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    send_fix(fix_of(PosTop - 10, 40, 35995, POS_Q_RTK_FIXED, HDG_Q_FIXED));

    // Zero tolerances reject even an unchanged fix; zero samples must act as one,
    // so a seeded block still tests the step instead of setting the reference.
    write_reg(CFG_SAMPLE_COUNT, '0);
    write_reg(CFG_POS_TOL, '0);
    write_reg(CFG_HDG_TOL, '0);
    send_fix(fix_of(5000, 5000, 0, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    send_fix(fix_of(5000, 5000, 0, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    // widest tolerances, steps exactly at them
    write_reg(CFG_POS_TOL, 16'hFFFF);
    write_reg(CFG_HDG_TOL, 16'(HeadingFull));
    send_fix(fix_of('0, '0, 0, POS_Q_RTK_FIXED, HDG_Q_FLOAT));
    send_fix(fix_of(65535, '0, 0, POS_Q_RTK_FIXED, HDG_Q_FLOAT));
    send_fix(fix_of('0, '0, 0, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    send_fix(fix_of('0, '0, 16'(HeadingFull), POS_Q_RTK_FIXED, HDG_Q_FIXED));

    // --- Random collecting, 255 samples so the reference is not set yet ---
    // upper data bits set on purpose: only the low byte is the sample count
    anchor_e = PosW'({$urandom(), $urandom()});
    anchor_n = PosW'({$urandom(), $urandom()});
    anchor_h = HdgW'($urandom_range(0, HeadingFull));
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       begin ptol = 30;                         htol = 30;                         end
        1:       begin ptol = 1;                          htol = 1;                          end
        2:       begin ptol = $urandom_range(2, 3000);    htol = $urandom_range(2, 3000);    end
        3:       begin ptol = 0;                          htol = 0;                          end
        default: begin ptol = 65535;                      htol = HeadingFull;                end
      endcase
      write_reg(CFG_SAMPLE_COUNT, 16'hFFFF);
      write_reg(CFG_POS_TOL, 16'(ptol));
      write_reg(CFG_HDG_TOL, 16'(htol));
      // second phase runs with no idling on either side
      gap_pct = (p == 1) ? 0 : 12;
      runs    = (p == 3) ? 40 : 150;
      for (int k = 0; k < runs; k++) send_fix(collect_fix(ptol, htol));
    end

    // --- Set the reference: sample count lowered mid-run, then steady fixes ---
    // If the run already holds more than the new count, the next qualified fix fires
    // and the divisor is the new count, not the number summed.
    write_reg(CFG_SAMPLE_COUNT, 16'($urandom_range(0, 12)));
    write_reg(CFG_POS_TOL, 16'd400);
    write_reg(CFG_HDG_TOL, 16'd400);
    while (!tracker.referenced) begin
      anchor_e = PosW'(nudge(64'(anchor_e), step_size(400), 64'(PosTop)));
      anchor_n = PosW'(nudge(64'(anchor_n), step_size(400), 64'(PosTop)));
      anchor_h = HdgW'(nudge(64'(anchor_h), step_size(400), 64'(HeadingFull)));
      send_fix(fix_of(anchor_e, anchor_n, anchor_h, POS_Q_RTK_FIXED, HDG_Q_FIXED));
    end

    // --- Relative for good: register changes must not matter any more ---
    write_reg(CFG_SAMPLE_COUNT, 16'd1);
    write_reg(CFG_POS_TOL, '0);
    write_reg(CFG_HDG_TOL, '0);
    for (int k = 0; k < 480; k++) send_fix(relative_fix());

    // drain: let the last request be noted, wait for every report, then a quiet spell
    fix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainTicks) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("gnss_stable_reference_averager_core_tb passed");
    end else begin
      $display("gnss_stable_reference_averager_core_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gsra_pkg.sv
rtl/gsra_in_if.sv
rtl/gsra_out_if.sv
rtl/gsra_div.sv
rtl/gnss_stable_reference_averager_core.sv
tb/sv/gnss_stable_reference_averager_core_tb.sv
